[src/mhd_pkg.sv]
// Shared constants and types for the multichannel hysteresis debouncer.
// No dependencies; used by the top level and its port checker.
`default_nettype none
package mhd_pkg;

   localparam int CHANNELS   = 16;  // debounced channels (1 to 64)
   localparam int IN_BITS    = 16;  // width of raw_levels and filtered_levels
   localparam int CNT_BITS   = 8;   // integrator width
   localparam int MASK_BITS  = 16;  // width of profile_select_mask
   localparam int IDX_BITS   = 3;   // width of the register index
   localparam int CSR_BITS   = 16;  // width of the register write data

   typedef enum logic [IDX_BITS-1:0] {
      REG_FAST_LIMIT   = 3'd0,
      REG_FAST_ON      = 3'd1,
      REG_FAST_OFF     = 3'd2,
      REG_SLOW_LIMIT   = 3'd3,
      REG_SLOW_ON      = 3'd4,
      REG_SLOW_OFF     = 3'd5,
      REG_PROFILE_MASK = 3'd6
   } reg_index_type;

   // One threshold profile
   typedef struct packed {
      logic [CNT_BITS-1:0] limit;
      logic [CNT_BITS-1:0] on_level;
      logic [CNT_BITS-1:0] off_level;
   } profile_type;

   localparam profile_type FAST_RESET = '{limit: 8'd1,  on_level: 8'd1, off_level: 8'd0};
   localparam profile_type SLOW_RESET = '{limit: 8'd10, on_level: 8'd7, off_level: 8'd3};
   localparam logic [MASK_BITS-1:0] MASK_RESET = 16'd784;

endpackage
`default_nettype wire

[src/multichannel_hysteresis_debouncer.sv]
// Multichannel hysteresis debouncer: per-channel saturating integrators with
// on/off thresholds, fast and slow profiles. Depends on mhd_pkg.
// A request passes through the input register, then the result register;
// throughput one tick per cycle, limited only by rsp_tready. Synchronous
// active-high reset restores the register defaults, clears all counters and
// levels and empties both pipeline registers.
`default_nettype none
module multichannel_hysteresis_debouncer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [mhd_pkg::IN_BITS-1:0]          req_tdata,  // [15:0] raw_levels
   // result stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [mhd_pkg::IN_BITS-1:0]               rsp_tdata,  // [15:0] filtered_levels
   // register write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mhd_pkg::IDX_BITS-1:0]         csr_index,
   input  wire logic [mhd_pkg::CSR_BITS-1:0]         csr_data
);

   // ---------------------------------------------------------------
   // Configuration registers. Writes are always taken; unknown index
   // is dropped. Values are truncated to the register widths.
   // ---------------------------------------------------------------
   mhd_pkg::profile_type                fast_ff, fast_in;
   mhd_pkg::profile_type                slow_ff, slow_in;
   logic [mhd_pkg::MASK_BITS-1:0]       mask_ff, mask_in;

   assign csr_ready = 1'b1;

   always_comb begin
      fast_in = fast_ff;
      slow_in = slow_ff;
      mask_in = mask_ff;
      if (csr_valid) begin
         unique case (mhd_pkg::reg_index_type'(csr_index))
            mhd_pkg::REG_FAST_LIMIT:   fast_in.limit     = csr_data[mhd_pkg::CNT_BITS-1:0];
            mhd_pkg::REG_FAST_ON:      fast_in.on_level  = csr_data[mhd_pkg::CNT_BITS-1:0];
            mhd_pkg::REG_FAST_OFF:     fast_in.off_level = csr_data[mhd_pkg::CNT_BITS-1:0];
            mhd_pkg::REG_SLOW_LIMIT:   slow_in.limit     = csr_data[mhd_pkg::CNT_BITS-1:0];
            mhd_pkg::REG_SLOW_ON:      slow_in.on_level  = csr_data[mhd_pkg::CNT_BITS-1:0];
            mhd_pkg::REG_SLOW_OFF:     slow_in.off_level = csr_data[mhd_pkg::CNT_BITS-1:0];
            mhd_pkg::REG_PROFILE_MASK: mask_in           = csr_data[mhd_pkg::MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff <= mhd_pkg::FAST_RESET;
         slow_ff <= mhd_pkg::SLOW_RESET;
         mask_ff <= mhd_pkg::MASK_RESET;
      end else begin
         fast_ff <= fast_in;
         slow_ff <= slow_in;
         mask_ff <= mask_in;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: input register feeds the result register.
   // The input stage moves on whenever the result slot is free or
   // is being drained, so a stalled result still lets one tick in.
   // ---------------------------------------------------------------
   logic                               in_valid_ff, in_valid_in;
   logic [mhd_pkg::IN_BITS-1:0]        in_raw_ff;
   logic                               out_valid_ff, out_valid_in;
   logic [mhd_pkg::IN_BITS-1:0]        out_data_ff, out_data_in;
   logic                               advance;
   logic                               req_xfer;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // ---------------------------------------------------------------
   // Channel state and update, applied when the input stage advances
   // ---------------------------------------------------------------
   logic [mhd_pkg::CNT_BITS-1:0] cnt_ff [mhd_pkg::CHANNELS];
   logic [mhd_pkg::CNT_BITS-1:0] cnt_in [mhd_pkg::CHANNELS];
   logic [mhd_pkg::CHANNELS-1:0] level_ff, level_in;

   always_comb begin
      for (int i = 0; i < mhd_pkg::CHANNELS; i++) begin
         logic                 raw_bit;
         logic                 slow;
         mhd_pkg::profile_type prof;
         logic [mhd_pkg::CNT_BITS-1:0] cnt;
         // channels past the field width see a raw 0 and the fast profile
         raw_bit = (i < mhd_pkg::IN_BITS)   ? in_raw_ff[i % mhd_pkg::IN_BITS] : 1'b0;
         slow    = (i < mhd_pkg::MASK_BITS) ? mask_ff[i % mhd_pkg::MASK_BITS] : 1'b0;
         prof    = slow ? slow_ff : fast_ff;
         cnt     = cnt_ff[i];
         level_in[i] = level_ff[i];
         if (raw_bit) begin
            if (cnt < prof.limit) cnt = cnt + 1'b1;
            if (cnt >= prof.on_level) level_in[i] = 1'b1;
         end else begin
            if (cnt != '0) cnt = cnt - 1'b1;
            if (cnt <= prof.off_level) level_in[i] = 1'b0;
         end
         cnt_in[i] = cnt;
      end
      for (int j = 0; j < mhd_pkg::IN_BITS; j++) begin
         out_data_in[j] = (j < mhd_pkg::CHANNELS) ? level_in[j % mhd_pkg::CHANNELS] : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         level_ff     <= '0;
         for (int i = 0; i < mhd_pkg::CHANNELS; i++) cnt_ff[i] <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            level_ff <= level_in;
            for (int i = 0; i < mhd_pkg::CHANNELS; i++) cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) in_raw_ff   <= req_tdata;
      if (advance)  out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

[src/mhd_checker.sv]
// Port-level checker for the debouncer, bound to the top level.
// Depends on mhd_pkg and multichannel_hysteresis_debouncer.
`default_nettype none
module mhd_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_tvalid,
   input wire logic                         req_tready,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [mhd_pkg::IN_BITS-1:0]  rsp_tdata
);

   // pipeline is empty straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a new result comes from an earlier request transfer
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without request");

   // input only backs up when the result side is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without output back-pressure");

endmodule

bind multichannel_hysteresis_debouncer mhd_checker u_mhd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
